// ===== rtl/core/cdq_pkg.sv =====
// Package for the circular deque unit: built depth, field widths, opcodes
// and the request and response transaction structs.
// No dependencies.
package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 5;
   localparam int WORD_W = 32;
   localparam int OP_W   = 3;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = OP_W'(0);
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = OP_W'(1);
   localparam logic [OP_W-1:0] OP_POP_FRONT  = OP_W'(2);
   localparam logic [OP_W-1:0] OP_POP_BACK   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_STATUS     = OP_W'(4);

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [CNT_W-1:0]         item_count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

endpackage

// ===== rtl/core/circular_deque_unit.sv =====
// Circular deque unit: double-ended queue held in a ring memory.
// Depends on cdq_pkg for the depth, opcodes and transaction structs.
//
// Use:
//   req channel (valid/ready) carries one transaction: an opcode (push front,
//   push back, pop front, pop back, status) and a data word for pushes.
//   rsp channel (valid/ready) returns one transaction per request: accepted
//   flag, front and back words after the operation (all ones when empty),
//   count, and empty and full flags.
//   csr_write_en/csr_write_data set the capacity (clamped to 1..DEPTH) and
//   empty the deque; write it only while no request is in flight.
// Sequence:
//   a request is accepted in the idle state, the ring memory is written and
//   both ends are read in the same edge; the response is registered from
//   the read state once the output register is free. Ring reads are
//   registered. A new request may be accepted while the previous response
//   still waits in the output register.
// Reset:
//   synchronous, active high; count and pointers go to zero, capacity to 16.
//   Memory contents are not cleared; an empty deque never reads them.
// Stall:
//   while rsp_ready is low the response holds and the next request, once
//   accepted, waits in the read state until the output register frees.
module circular_deque_unit
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic [CNT_W-1:0] csr_write_data
);

   localparam logic       S_IDLE  = 1'b0;
   localparam logic       S_READ  = 1'b1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         capacity_ff;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ok_ff, ok_in;
   logic                     fwd_head_ff, fwd_tail_ff;
   logic [WORD_W-1:0]        wr_data_ff;
   logic [WORD_W-1:0]        head_rd_ff, tail_rd_ff;
   logic [WORD_W-1:0]        ring_store_ff [DEPTH];
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]         cap_eff;
   logic                     req_take;
   logic                     rsp_load;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_wa;
   logic                     now_full, now_empty, res_empty;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(i) + CNT_W'(1);
      return (inc >= cap) ? '0 : inc[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] last;
      last = cap - CNT_W'(1);
      return (i == '0 || CNT_W'(i) >= cap) ? last[IDX_W-1:0] : i - IDX_W'(1);
   endfunction

   // clamp the programmed capacity to 1..DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (capacity_ff > DEPTH_C) begin
         cap_eff = DEPTH_C;
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_READ) && (!rsp_valid_ff || rsp_ready);
   assign now_full  = (count_ff >= cap_eff);
   assign now_empty = (count_ff == '0);

   // decode the opcode and work out pointers, count and the memory write
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = head_ff;
      case (req_data.opcode) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (!now_full) begin
               if (now_empty) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (req_data.opcode == OP_PUSH_FRONT) begin
                  head_in = ring_prev(head_ff, cap_eff);
               end else begin
                  tail_in = ring_next(tail_ff, cap_eff);
               end
               mem_we   = 1'b1;
               mem_wa   = (req_data.opcode == OP_PUSH_FRONT) ? head_in : tail_in;
               count_in = count_ff + CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (!now_empty) begin
               if (count_ff == CNT_W'(1)) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end else begin
                  if (req_data.opcode == OP_POP_FRONT) begin
                     head_in = ring_next(head_ff, cap_eff);
                  end else begin
                     tail_in = ring_prev(tail_ff, cap_eff);
                  end
                  count_in = count_ff - CNT_W'(1);
               end
               ok_in = 1'b1;
            end
         end
         OP_STATUS: begin
            ok_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequence: accept in idle, collect the read data in the read state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold control state; apply capacity writes and accepted operations
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
            head_ff     <= '0;
            tail_ff     <= '0;
            count_ff    <= '0;
         end else if (req_take) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   // ring memory: one write port, two registered read ports at the new ends
   always_ff @(posedge clock) begin
      if (mem_we && req_take) begin
         ring_store_ff[mem_wa] <= req_data.value;
      end
      if (req_take) begin
         head_rd_ff <= ring_store_ff[head_in];
         tail_rd_ff <= ring_store_ff[tail_in];
      end
   end

   // capture forwarding for a read that meets the write of the same edge
   always_ff @(posedge clock) begin
      if (req_take) begin
         ok_ff       <= ok_in;
         wr_data_ff  <= req_data.value;
         fwd_head_ff <= mem_we && (mem_wa == head_in);
         fwd_tail_ff <= mem_we && (mem_wa == tail_in);
      end
   end

   // assemble the response transaction
   assign res_empty = (count_ff == '0);
   always_comb begin
      rsp_data_in.accepted    = ok_ff;
      rsp_data_in.front_value = res_empty ? '1 : (fwd_head_ff ? wr_data_ff : head_rd_ff);
      rsp_data_in.back_value  = res_empty ? '1 : (fwd_tail_ff ? wr_data_ff : tail_rd_ff);
      rsp_data_in.item_count  = count_ff;
      rsp_data_in.is_empty    = res_empty;
      rsp_data_in.is_full     = (count_ff >= cap_eff);
   end

   // output register: load when free or being taken, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // pointers stay inside the effective capacity
   assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(head_ff) < cap_eff) && (CNT_W'(tail_ff) < cap_eff))
      else $error("deque pointer beyond capacity");

   // count never exceeds the effective capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= cap_eff)
      else $error("deque count beyond capacity");

   // an empty deque has both pointers at the first entry
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty deque with stray pointers");

   // a response is only loaded from the read state
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == S_READ))
      else $error("response loaded outside read state");

   // an accepted request drops req_ready in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request accepted twice in a row");

endmodule
